@@ hdl/ppac_pkg.sv @@
package ppac_pkg;

    // request function codes
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_UP     = 3'd1;
    localparam logic [2:0] FUNC_DOWN   = 3'd2;
    localparam logic [2:0] FUNC_DRIVE  = 3'd3;
    localparam logic [2:0] FUNC_TARGET = 3'd4;
    localparam logic [2:0] FUNC_STOP   = 3'd5;

    // motor direction codes
    localparam logic [1:0] DIR_RELEASE  = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P    = 3'd0;
    localparam logic [2:0] CFG_GAIN_I    = 3'd1;
    localparam logic [2:0] CFG_GAIN_D    = 3'd2;
    localparam logic [2:0] CFG_INT_LIMIT = 3'd3;
    localparam logic [2:0] CFG_DEADZONE  = 3'd4;
    localparam logic [2:0] CFG_REVERSE   = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // three products of up to 49 bits summed
    localparam int SUM_W = 51;

    localparam logic [15:0]        AT_TARGET_DRIVE = 16'(65535 / 50);
    localparam logic signed [31:0] AT_TARGET_ERROR = 32'sd10;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [16:0] drive_signed;
        logic [15:0]        drive_magnitude;
        logic [1:0]         direction;
        logic signed [31:0] position_count;
        logic               at_target;
        logic               position_mode;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [30:0]        integral_limit;
        logic [15:0]        deadzone;
        logic               reverse;
    } cfg_t;

    // after the state update
    typedef struct packed {
        logic               tick;
        logic               drive_write;
        logic signed [31:0] drive_value;
        logic signed [31:0] error;
        logic signed [32:0] diff;
        logic signed [31:0] integral;
        logic               mode;
        logic [31:0]        position;
    } track_t;

    // after the multipliers
    typedef struct packed {
        logic               drive_write;
        logic signed [47:0] prod_p;
        logic signed [47:0] prod_i;
        logic signed [48:0] prod_d;
        logic signed [31:0] error;
        logic               mode;
        logic [31:0]        position;
    } prod_t;

endpackage

@@ hdl/ppac_track.sv @@
module ppac_track #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                step,
    input  ppac_pkg::req_t      req,
    input  ppac_pkg::cfg_t      cfg,
    output ppac_pkg::track_t    stage
);

    localparam int DIFF_W = (POSITION_WIDTH > 32 ? POSITION_WIDTH : 32) + 1;
    localparam logic signed [DIFF_W-1:0] ERR_MAX = DIFF_W'(32'sh7fff_ffff);
    localparam logic signed [DIFF_W-1:0] ERR_MIN = -ERR_MAX - DIFF_W'(1);
    localparam logic signed [32:0]       INT_MIN = -33'sh0_7fff_ffff - 33'sd1;

    ppac_pkg::req_t             req_reg;
    ppac_pkg::track_t           stage_reg;
    ppac_pkg::track_t           stage_next;

    logic [POSITION_WIDTH-1:0]  position_reg, position_next;
    logic signed [31:0]         target_reg, target_next;
    logic                       mode_reg, mode_next;
    logic signed [31:0]         error_reg, error_next;
    logic signed [31:0]         error_before_reg, error_before_next;
    logic signed [31:0]         integral_reg, integral_next;

    logic signed [DIFF_W-1:0]   err_wide;
    logic signed [31:0]         error_tick;
    logic signed [32:0]         diff_tick;
    logic signed [32:0]         isum;
    logic signed [31:0]         integral_tick;
    logic                       is_tick;

    always_comb
    begin
        err_wide = DIFF_W'(target_reg) - DIFF_W'($signed(position_reg));
        if (err_wide > ERR_MAX)
        begin
            error_tick = 32'(ERR_MAX);
        end
        else if (err_wide < ERR_MIN)
        begin
            error_tick = 32'(ERR_MIN);
        end
        else
        begin
            error_tick = 32'(err_wide);
        end

        diff_tick = 33'(error_tick) - 33'(error_before_reg);

        // floor at the register range, ceiling at the configured limit
        isum = 33'(integral_reg) + 33'(error_tick);
        if (isum < INT_MIN)
        begin
            integral_tick = 32'(INT_MIN);
        end
        else if (isum > $signed({2'b00, cfg.integral_limit}))
        begin
            integral_tick = $signed({1'b0, cfg.integral_limit});
        end
        else
        begin
            integral_tick = 32'(isum);
        end
    end

    always_comb
    begin
        position_next     = position_reg;
        target_next       = target_reg;
        mode_next         = mode_reg;
        error_next        = error_reg;
        error_before_next = error_before_reg;
        integral_next     = integral_reg;
        is_tick           = 1'b0;
        case (req_reg.func)
            ppac_pkg::FUNC_TICK:
            begin
                if (mode_reg)
                begin
                    is_tick           = 1'b1;
                    error_next        = error_tick;
                    error_before_next = error_tick;
                    integral_next     = integral_tick;
                end
            end
            ppac_pkg::FUNC_UP:
            begin
                position_next = position_reg + POSITION_WIDTH'(1);
            end
            ppac_pkg::FUNC_DOWN:
            begin
                position_next = position_reg - POSITION_WIDTH'(1);
            end
            ppac_pkg::FUNC_DRIVE:
            begin
                mode_next = 1'b0;
            end
            ppac_pkg::FUNC_TARGET:
            begin
                if (!mode_reg)
                begin
                    error_next        = '0;
                    error_before_next = '0;
                    integral_next     = '0;
                    mode_next         = 1'b1;
                end
                target_next = req_reg.value;
            end
            ppac_pkg::FUNC_STOP:
            begin
                mode_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stage_next.tick        = is_tick;
        stage_next.drive_write = is_tick || (req_reg.func == ppac_pkg::FUNC_DRIVE)
                                 || (req_reg.func == ppac_pkg::FUNC_STOP);
        stage_next.drive_value = (req_reg.func == ppac_pkg::FUNC_DRIVE) ? req_reg.value : '0;
        stage_next.error       = error_next;
        stage_next.diff        = diff_tick;
        stage_next.integral    = integral_next;
        stage_next.mode        = mode_next;
        stage_next.position    = 32'(position_next);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req;
        end
        if (step)
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            target_reg       <= '0;
            mode_reg         <= 1'b0;
            error_reg        <= '0;
            error_before_reg <= '0;
            integral_reg     <= '0;
        end
        else if (step)
        begin
            position_reg     <= position_next;
            target_reg       <= target_next;
            mode_reg         <= mode_next;
            error_reg        <= error_next;
            error_before_reg <= error_before_next;
            integral_reg     <= integral_next;
        end
    end

    assign stage = stage_reg;

endmodule

@@ hdl/ppac_mult.sv @@
module ppac_mult (
    input  logic                clk,
    input  logic                load,
    input  ppac_pkg::track_t    track,
    input  ppac_pkg::cfg_t      cfg,
    output ppac_pkg::prod_t     prod
);

    ppac_pkg::prod_t prod_reg;
    ppac_pkg::prod_t prod_next;

    always_comb
    begin
        prod_next.drive_write = track.drive_write;
        prod_next.error       = track.error;
        prod_next.mode        = track.mode;
        prod_next.position    = track.position;
        if (track.tick)
        begin
            prod_next.prod_p = 48'(cfg.gain_p) * 48'(track.error);
            prod_next.prod_i = 48'(cfg.gain_i) * 48'(track.integral);
            prod_next.prod_d = 49'(cfg.gain_d) * 49'(track.diff);
        end
        else
        begin
            // a written drive value rides the proportional lane
            prod_next.prod_p = 48'(track.drive_value);
            prod_next.prod_i = '0;
            prod_next.prod_d = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ hdl/ppac_drive.sv @@
module ppac_drive #(
    parameter int DRIVE_MAX = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ppac_pkg::prod_t     prod,
    input  ppac_pkg::cfg_t      cfg,
    output ppac_pkg::rsp_t      rsp
);

    localparam logic signed [ppac_pkg::SUM_W-1:0] LIMIT = ppac_pkg::SUM_W'(DRIVE_MAX);

    logic signed [ppac_pkg::SUM_W-1:0] sum;
    logic signed [16:0]                clipped;
    logic [16:0]                       clip_mag;
    logic signed [16:0]                shaped;
    logic signed [16:0]                drive_reg, drive_next;
    logic [16:0]                       drive_mag;
    ppac_pkg::rsp_t                    rsp_reg, rsp_next;

    always_comb
    begin
        sum = ppac_pkg::SUM_W'(prod.prod_p) + ppac_pkg::SUM_W'(prod.prod_i)
              + ppac_pkg::SUM_W'(prod.prod_d);
        if (sum > LIMIT)
        begin
            clipped = 17'(LIMIT);
        end
        else if (sum < -LIMIT)
        begin
            clipped = 17'(-LIMIT);
        end
        else
        begin
            clipped = 17'(sum);
        end
        clip_mag = clipped[16] ? 17'(-clipped) : 17'(clipped);
        shaped   = (clip_mag <= {1'b0, cfg.deadzone}) ? '0 : clipped;

        drive_next = prod.drive_write ? shaped : drive_reg;
        drive_mag  = drive_next[16] ? 17'(-drive_next) : 17'(drive_next);

        rsp_next.drive_signed    = drive_next;
        rsp_next.drive_magnitude = drive_mag[15:0];
        if (drive_next > 17'sd0)
        begin
            rsp_next.direction = cfg.reverse ? ppac_pkg::DIR_BACKWARD : ppac_pkg::DIR_FORWARD;
        end
        else if (drive_next < 17'sd0)
        begin
            rsp_next.direction = cfg.reverse ? ppac_pkg::DIR_FORWARD : ppac_pkg::DIR_BACKWARD;
        end
        else
        begin
            rsp_next.direction = ppac_pkg::DIR_RELEASE;
        end
        rsp_next.position_count = $signed(prod.position);
        rsp_next.at_target      = (drive_mag < {1'b0, ppac_pkg::AT_TARGET_DRIVE})
                                  && (prod.error < ppac_pkg::AT_TARGET_ERROR)
                                  && (prod.error > -ppac_pkg::AT_TARGET_ERROR);
        rsp_next.position_mode  = prod.mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
        end
        else if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ hdl/pid_position_axis_controller_top.sv @@
// throughput: one request per cycle unless rsp_stall is high, through input
// register, state update, multiplier register and result register, each stage
// refilling independently
// reset: asynchronous active low; position, target, mode, errors, integral and
// drive clear to zero, gains and deadzone to zero, integral limit to 2^31-1
module pid_position_axis_controller_top #(
    parameter int POSITION_WIDTH = 32,
    parameter int DRIVE_MAX      = 65535
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ppac_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ppac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ppac_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ppac_pkg::rsp_t                      rsp
);

    ppac_pkg::cfg_t   cfg_reg;
    ppac_pkg::track_t track;
    ppac_pkg::prod_t  prod;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic accept;

    // a stage loads when it is empty or its successor moves on
    assign en4    = !v4_reg || !rsp_stall;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = req_valid && en1;

    assign req_stall = !en1;
    assign rsp_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '1;
            cfg_reg.deadzone       <= '0;
            cfg_reg.reverse        <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ppac_pkg::CFG_GAIN_P:    cfg_reg.gain_p         <= $signed(cfg_data[15:0]);
                ppac_pkg::CFG_GAIN_I:    cfg_reg.gain_i         <= $signed(cfg_data[15:0]);
                ppac_pkg::CFG_GAIN_D:    cfg_reg.gain_d         <= $signed(cfg_data[15:0]);
                ppac_pkg::CFG_INT_LIMIT: cfg_reg.integral_limit <= cfg_data[30:0];
                ppac_pkg::CFG_DEADZONE:  cfg_reg.deadzone       <= cfg_data[15:0];
                ppac_pkg::CFG_REVERSE:   cfg_reg.reverse        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ppac_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .step  (v1_reg && en2),
        .req   (req),
        .cfg   (cfg_reg),
        .stage (track)
    );

    ppac_mult u_mult (
        .clk   (clk),
        .load  (v2_reg && en3),
        .track (track),
        .cfg   (cfg_reg),
        .prod  (prod)
    );

    ppac_drive #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_drive (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (v3_reg && en4),
        .prod  (prod),
        .cfg   (cfg_reg),
        .rsp   (rsp)
    );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DRIVE_LIMIT  = 65535;
    localparam longint INT32_HI     = 64'sd2147483647;
    localparam longint INT32_LO     = -64'sd2147483648;
    localparam int     HOLD_CYCLES  = 150;
    localparam int     LIMIT_CYCLES = 300000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [ppac_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ppac_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic       req_valid;
    logic       req_stall;
    ppac_pkg::req_t req;
    logic       rsp_valid;
    logic       rsp_stall;
    ppac_pkg::rsp_t rsp;

    pid_position_axis_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // axis state as the controller should hold it
    longint      kp = 0;
    longint      ki = 0;
    longint      kd = 0;
    longint      int_lim = INT32_HI;
    longint      dz = 0;
    logic        rev = 1'b0;
    logic [31:0] pos_cnt = '0;
    longint      tgt = 0;
    logic        pid_on = 1'b0;
    longint      err_now = 0;
    longint      err_prev = 0;
    longint      err_sum = 0;
    longint      drv = 0;

    ppac_pkg::rsp_t axis_status_q[$];
    ppac_pkg::rsp_t status_want;

    int   mismatch_count = 0;
    int   status_checked = 0;
    int   requests_sent = 0;
    int   settings_used = 0;
    int   cycle_count = 0;
    int   burst_left = 0;
    logic gaps_on = 1'b1;
    logic hold_active = 1'b0;
    event hold_off_ev;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clip_drive(longint u);
        if (u > DRIVE_LIMIT)
            u = DRIVE_LIMIT;
        if (u < -DRIVE_LIMIT)
            u = -DRIVE_LIMIT;
        if ((u < 0 ? -u : u) <= dz)
            u = 0;
        return u;
    endfunction

    // applies one request to the axis state and returns the status it should report
    function automatic ppac_pkg::rsp_t axis_advance(ppac_pkg::req_t r);
        longint e;
        longint s;
        longint mag;
        ppac_pkg::rsp_t o;
        case (r.func)
            ppac_pkg::FUNC_TICK:
                if (pid_on)
                begin
                    e = tgt - longint'($signed(pos_cnt));
                    if (e > INT32_HI)
                        e = INT32_HI;
                    else if (e < INT32_LO)
                        e = INT32_LO;
                    s = err_sum + e;
                    if (s < INT32_LO)
                        s = INT32_LO;
                    if (s > int_lim)
                        s = int_lim;
                    err_sum = s;
                    drv = clip_drive(kp * e + kd * (e - err_prev) + ki * s);
                    err_now = e;
                    err_prev = e;
                end
            ppac_pkg::FUNC_UP:
                pos_cnt = pos_cnt + 32'd1;
            ppac_pkg::FUNC_DOWN:
                pos_cnt = pos_cnt - 32'd1;
            ppac_pkg::FUNC_DRIVE:
            begin
                pid_on = 1'b0;
                drv = clip_drive(longint'($signed(r.value)));
            end
            ppac_pkg::FUNC_TARGET:
            begin
                // only a fresh entry into position mode clears the loop history
                if (!pid_on)
                begin
                    err_now = 0;
                    err_prev = 0;
                    err_sum = 0;
                    pid_on = 1'b1;
                end
                tgt = longint'($signed(r.value));
            end
            ppac_pkg::FUNC_STOP:
            begin
                pid_on = 1'b0;
                drv = clip_drive(0);
            end
            default:
                ;
        endcase
        mag = (drv < 0) ? -drv : drv;
        o.drive_signed    = 17'(drv);
        o.drive_magnitude = 16'(mag);
        if (drv > 0)
            o.direction = rev ? ppac_pkg::DIR_BACKWARD : ppac_pkg::DIR_FORWARD;
        else if (drv < 0)
            o.direction = rev ? ppac_pkg::DIR_FORWARD : ppac_pkg::DIR_BACKWARD;
        else
            o.direction = ppac_pkg::DIR_RELEASE;
        o.position_count = pos_cnt;
        o.at_target = (mag < longint'(ppac_pkg::AT_TARGET_DRIVE)) &&
                      (((err_now < 0) ? -err_now : err_now)
                       < longint'(ppac_pkg::AT_TARGET_ERROR));
        o.position_mode = pid_on;
        return o;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_request(input logic [2:0] f, input logic [31:0] v);
        ppac_pkg::req_t r;
        r.func  = f;
        r.value = v;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                req_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        req = r;
        req_valid = 1'b1;
        do @(posedge clk); while (req_stall);
        axis_status_q.push_back(axis_advance(r));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid = 1'b0;
        while (axis_status_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [30:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            ppac_pkg::CFG_GAIN_P:    kp = longint'($signed(data[15:0]));
            ppac_pkg::CFG_GAIN_I:    ki = longint'($signed(data[15:0]));
            ppac_pkg::CFG_GAIN_D:    kd = longint'($signed(data[15:0]));
            ppac_pkg::CFG_INT_LIMIT: int_lim = longint'(data);
            ppac_pkg::CFG_DEADZONE:  dz = longint'(data[15:0]);
            ppac_pkg::CFG_REVERSE:   rev = data[0];
            default:                 ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                              input logic [30:0] lim, input logic [15:0] dzone, input logic r);
        drain_results();
        write_register(ppac_pkg::CFG_GAIN_P, {15'd0, p});
        write_register(ppac_pkg::CFG_GAIN_I, {15'd0, i});
        write_register(ppac_pkg::CFG_GAIN_D, {15'd0, d});
        write_register(ppac_pkg::CFG_INT_LIMIT, lim);
        write_register(ppac_pkg::CFG_DEADZONE, {15'd0, dzone});
        write_register(ppac_pkg::CFG_REVERSE, {30'd0, r});
        settings_used++;
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] m;
        case ($urandom_range(0, 5))
            0:       m = $urandom;
            1:       m = $urandom_range(0, 300);
            2:       m = 32'd65535 + $urandom_range(0, 2) - 1;
            3:       m = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4:       m = 32'(dz) + $urandom_range(0, 2) - 1;
            default: m = $urandom_range(0, 70000);
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // closed loop traffic: encoder events mostly follow the predicted drive so
    // the axis settles and the at-target flag gets exercised
    task automatic run_traffic(input int count);
        int          done;
        int          pick;
        logic [31:0] v;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            done++;
            if (pick < 40)
                send_request(ppac_pkg::FUNC_TICK, $urandom);
            else if (pick < 70)
            begin
                if ($urandom_range(0, 4) != 0 && drv != 0)
                    send_request((drv > 0) ? ppac_pkg::FUNC_UP : ppac_pkg::FUNC_DOWN,
                                 $urandom);
                else
                    send_request($urandom_range(0, 1) ? ppac_pkg::FUNC_UP
                                                      : ppac_pkg::FUNC_DOWN,
                                 $urandom);
            end
            else if (pick < 80)
            begin
                v = pos_cnt + $urandom_range(0, 400) - 200;
                send_request(ppac_pkg::FUNC_TARGET, v);
            end
            else if (pick < 84)
                send_request(ppac_pkg::FUNC_TARGET, rand_value());
            else if (pick < 91)
                send_request(ppac_pkg::FUNC_DRIVE, rand_value());
            else if (pick < 95)
                send_request(ppac_pkg::FUNC_STOP, $urandom);
            else
            begin
                // unused codes, ignored by the block
                send_request(3'($urandom_range(6, 7)), $urandom);
                done--;
            end
        end
    endtask

    task automatic test_reset_state();
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_UP, 32'hFFFF_FFFF);
        send_request(ppac_pkg::FUNC_DOWN, 32'h0);
        send_request(3'd7, 32'h5555_5555);
    endtask

    task automatic test_open_drive();
        set_config(16'd0, 16'd0, 16'd0, 31'h7FFF_FFFF, 16'd100, 1'b1);
        send_request(ppac_pkg::FUNC_DRIVE, 32'h7FFF_FFFF);
        send_request(ppac_pkg::FUNC_DRIVE, 32'h8000_0000);
        send_request(ppac_pkg::FUNC_DRIVE, 32'd65536);
        send_request(ppac_pkg::FUNC_DRIVE, -32'sd65535);
        send_request(ppac_pkg::FUNC_DRIVE, 32'd100);
        send_request(ppac_pkg::FUNC_DRIVE, -32'sd101);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_STOP, 32'hAAAA_AAAA);
        send_request(ppac_pkg::FUNC_UP, 32'h0);
        send_request(ppac_pkg::FUNC_DOWN, 32'h0);
        send_request(ppac_pkg::FUNC_DOWN, 32'h0);
    endtask

    task automatic test_position_mode();
        set_config(16'd1, 16'd1, 16'hFFFF, 31'd1000, 16'd0, 1'b0);
        // error saturates high, integral hits its limit
        send_request(ppac_pkg::FUNC_TARGET, 32'h7FFF_FFFF);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_UP, 32'h0);
        send_request(ppac_pkg::FUNC_UP, 32'h0);
        // retarget inside position mode keeps history, error saturates low
        send_request(ppac_pkg::FUNC_TARGET, 32'h8000_0000);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
        send_request(ppac_pkg::FUNC_TARGET, 32'h0);
        send_request(ppac_pkg::FUNC_DRIVE, 32'd7);
        send_request(ppac_pkg::FUNC_TARGET, 32'd3);
        send_request(ppac_pkg::FUNC_TICK, 32'h0);
    endtask

    task automatic test_backpressure();
        set_config(16'd20, 16'd1, 16'd5, 31'd5000, 16'd10, 1'b0);
        -> hold_off_ev;
        gaps_on = 1'b0;
        run_traffic(40);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_gains();
        int ph;
        for (ph = 0; ph < 7; ph++)
        begin
            if (ph == 0)
                set_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1);
            else if (ph == 1)
                set_config(16'h8000, 16'h8000, 16'h8000, 31'd0, 16'd0, 1'b0);
            else if ($urandom_range(0, 3) != 0)
                set_config(16'($urandom_range(0, 72) - 8), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 40) - 8), 31'($urandom_range(0, 5000)),
                           16'($urandom_range(0, 300)), 1'($urandom));
            else
                set_config(16'($urandom), 16'($urandom), 16'($urandom), 31'($urandom),
                           16'($urandom), 1'($urandom));
            run_traffic(215);
        end
    endtask

    // receiver stall pattern, picks a new random style each time its current run ends
    initial
    begin
        int   stall_left;
        int   stall_style;
        int   beat;
        logic pat;
        stall_left = 0;
        stall_style = 0;
        beat = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 80);
            end
            stall_left--;
            beat++;
            case (stall_style)
                1:       pat = ($urandom_range(0, 3) == 0);
                2:       pat = (beat % 3 == 0);
                3:       pat = $urandom_range(0, 1);
                default: pat = 1'b0;
            endcase
            rsp_stall = hold_active || pat;
        end
    end

    // long receiver hold-off so the pipeline fills and stalls requests
    initial
    begin
        forever
        begin
            @(hold_off_ev);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (axis_status_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("status with no pending request: %p", rsp);
            end
            else
            begin
                status_want = axis_status_q.pop_front();
                status_checked++;
                if (rsp.drive_signed !== status_want.drive_signed ||
                    rsp.drive_magnitude !== status_want.drive_magnitude ||
                    rsp.direction !== status_want.direction ||
                    rsp.position_count !== status_want.position_count ||
                    rsp.at_target !== status_want.at_target ||
                    rsp.position_mode !== status_want.position_mode)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("status %0d mismatch", status_checked);
                        $display("  expected drive %0d mag %0d dir %0d pos %0d at %0d mode %0d",
                                 status_want.drive_signed, status_want.drive_magnitude,
                                 status_want.direction, status_want.position_count,
                                 status_want.at_target, status_want.position_mode);
                        $display("  actual   drive %0d mag %0d dir %0d pos %0d at %0d mode %0d",
                                 rsp.drive_signed, rsp.drive_magnitude, rsp.direction,
                                 rsp.position_count, rsp.at_target, rsp.position_mode);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d statuses pending", cycle_count,
                 axis_status_q.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_open_drive();
        test_position_mode();
        test_backpressure();
        test_random_gains();
        drain_results();

        mismatch_count += axis_status_q.size();
        $display("%0d requests over %0d register settings, %0d statuses checked",
                 requests_sent, settings_used, status_checked);
        $display("open drive, PID position mode, saturation and receiver hold-off, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
